FILE: src/tlbps_pkg.sv
// ----------------------------------------------------------------------------
// tlbps_pkg
// Types, codes and helpers of the two-LED blink pattern sequencer.
// ----------------------------------------------------------------------------
package tlbps_pkg;

    // Command field codes
    localparam logic CMD_MODE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Display mode codes
    localparam logic [3:0] MODE_ALL_OFF   = 4'd0;
    localparam logic [3:0] MODE_ALTERNATE = 4'd1;
    localparam logic [3:0] MODE_FLASH_5S  = 4'd2;
    localparam logic [3:0] MODE_BLINK_1   = 4'd3;
    localparam logic [3:0] MODE_BLINK_2   = 4'd4;
    localparam logic [3:0] MODE_LED1_ON   = 4'd5;
    localparam logic [3:0] MODE_LED2_ON   = 4'd6;
    localparam logic [3:0] MODE_SINGLE    = 4'd7;
    localparam logic [3:0] MODE_BURST     = 4'd8;
    localparam logic [3:0] MODE_ALL_ON    = 4'd9;

    // Per-pin code: bit0 driven, bit1 level
    localparam logic [1:0] PIN_RELEASED   = 2'b00;
    localparam logic [1:0] PIN_DRIVE_LOW  = 2'b01;
    localparam logic [1:0] PIN_DRIVE_HIGH = 2'b11;

    // Step thresholds
    localparam logic [3:0] ALT_WRAP     = 4'd10;
    localparam logic [3:0] FLASH_WRAP   = 4'd10;
    localparam logic [3:0] SINGLE_END   = 4'd3;
    localparam logic [3:0] BURST_END    = 4'd9;

    // Prescaler periods in base ticks
    localparam logic [3:0] PER_500MS = 4'd5;
    localparam logic [3:0] PER_1S    = 4'd10;
    localparam logic [3:0] PER_100MS = 4'd1;
    localparam logic [3:0] PER_200MS = 4'd2;
    localparam logic [3:0] PER_NONE  = 4'd0;

    typedef enum logic [3:0] {
        PAT_NONE      = 4'd0,
        PAT_ALTERNATE = 4'd1,
        PAT_FLASH_5S  = 4'd2,
        PAT_BLINK_1   = 4'd3,
        PAT_BLINK_2   = 4'd4,
        PAT_SINGLE    = 4'd7,
        PAT_BURST     = 4'd8
    } t_pattern;

    typedef struct packed {
        t_pattern   pattern;
        logic [3:0] step;
        logic [3:0] prescale;
        logic [3:0] pins;     // {pin1 code, pin0 code}
    } t_seq_state;

    function automatic logic [3:0] pin_pair(input logic [1:0] p0, input logic [1:0] p1);
        pin_pair = {p1, p0};
    endfunction

    function automatic logic [3:0] period_of(input t_pattern pat);
        unique case (pat)
            PAT_ALTERNATE, PAT_FLASH_5S: period_of = PER_500MS;
            PAT_BLINK_1, PAT_BLINK_2:    period_of = PER_1S;
            PAT_SINGLE:                  period_of = PER_100MS;
            PAT_BURST:                   period_of = PER_200MS;
            default:                     period_of = PER_NONE;
        endcase
    endfunction

endpackage

FILE: src/tlbps_if.sv
// ----------------------------------------------------------------------------
// tlbps_in_if / tlbps_out_if
// Valid/ready channels for command items and pin result items.
// ----------------------------------------------------------------------------
interface tlbps_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [3:0] mode;

    modport source (output valid, output cmd, output mode, input ready);
    modport sink   (input valid, input cmd, input mode, output ready);
endinterface

interface tlbps_out_if;
    logic valid;
    logic ready;
    logic led0_driven;
    logic led0_level;
    logic led1_driven;
    logic led1_level;
    logic pattern_busy;

    modport source (output valid, output led0_driven, output led0_level,
                    output led1_driven, output led1_level, output pattern_busy,
                    input ready);
    modport sink   (input valid, input led0_driven, input led0_level,
                    input led1_driven, input led1_level, input pattern_busy,
                    output ready);
endinterface

FILE: src/tlbps_next.sv
// ----------------------------------------------------------------------------
// tlbps_next
// Next-state logic: mode decode, tick prescaler and pattern steps.
// ----------------------------------------------------------------------------
module tlbps_next (
    input  tlbps_pkg::t_seq_state i_state,
    input  logic                  i_cmd,
    input  logic [3:0]            i_mode,
    output tlbps_pkg::t_seq_state o_next
);

    logic [3:0] step_inc;
    logic [3:0] pre_inc;
    logic [3:0] period;

    assign step_inc = i_state.step + 4'd1;
    assign pre_inc  = i_state.prescale + 4'd1;
    assign period   = tlbps_pkg::period_of(i_state.pattern);

    always_comb begin
        o_next = i_state;
        if (i_cmd == tlbps_pkg::CMD_MODE) begin
            // any mode command stops the pattern first
            o_next.pattern  = tlbps_pkg::PAT_NONE;
            o_next.step     = 4'd0;
            o_next.prescale = 4'd0;
            unique case (i_mode)
                tlbps_pkg::MODE_ALL_OFF: begin
                    o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                      tlbps_pkg::PIN_RELEASED);
                end
                tlbps_pkg::MODE_ALTERNATE: o_next.pattern = tlbps_pkg::PAT_ALTERNATE;
                tlbps_pkg::MODE_FLASH_5S:  o_next.pattern = tlbps_pkg::PAT_FLASH_5S;
                tlbps_pkg::MODE_BLINK_1:   o_next.pattern = tlbps_pkg::PAT_BLINK_1;
                tlbps_pkg::MODE_BLINK_2:   o_next.pattern = tlbps_pkg::PAT_BLINK_2;
                tlbps_pkg::MODE_LED1_ON: begin
                    o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_LOW,
                                                      tlbps_pkg::PIN_DRIVE_HIGH);
                end
                tlbps_pkg::MODE_LED2_ON: begin
                    o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                      tlbps_pkg::PIN_DRIVE_LOW);
                end
                tlbps_pkg::MODE_SINGLE: begin
                    o_next.pins    = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                         tlbps_pkg::PIN_DRIVE_LOW);
                    o_next.pattern = tlbps_pkg::PAT_SINGLE;
                end
                tlbps_pkg::MODE_BURST: begin
                    o_next.pins    = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_LOW,
                                                         tlbps_pkg::PIN_DRIVE_LOW);
                    o_next.pattern = tlbps_pkg::PAT_BURST;
                end
                tlbps_pkg::MODE_ALL_ON: begin
                    o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                      tlbps_pkg::PIN_DRIVE_HIGH);
                end
                default: ; // unknown mode: pattern stopped, pins held
            endcase
        end else if (period != tlbps_pkg::PER_NONE) begin
            if (pre_inc < period) begin
                o_next.prescale = pre_inc;
            end else begin
                o_next.prescale = 4'd0;
                unique case (i_state.pattern)
                    tlbps_pkg::PAT_ALTERNATE: begin
                        o_next.step = (step_inc >= tlbps_pkg::ALT_WRAP) ? 4'd0 : step_inc;
                        if (o_next.step[0]) begin
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_LOW,
                                                              tlbps_pkg::PIN_DRIVE_HIGH);
                        end else begin
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                              tlbps_pkg::PIN_DRIVE_LOW);
                        end
                    end
                    tlbps_pkg::PAT_FLASH_5S: begin
                        if (step_inc < tlbps_pkg::FLASH_WRAP) begin
                            o_next.step = step_inc;
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                              tlbps_pkg::PIN_RELEASED);
                        end else begin
                            o_next.step = 4'd0;
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_LOW,
                                                              tlbps_pkg::PIN_DRIVE_HIGH);
                        end
                    end
                    tlbps_pkg::PAT_BLINK_1, tlbps_pkg::PAT_BLINK_2: begin
                        o_next.step = i_state.step ^ 4'd1;
                        if (o_next.step == 4'd0) begin
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                              tlbps_pkg::PIN_RELEASED);
                        end else if (i_state.pattern == tlbps_pkg::PAT_BLINK_1) begin
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_LOW,
                                                              tlbps_pkg::PIN_DRIVE_HIGH);
                        end else begin
                            o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                              tlbps_pkg::PIN_DRIVE_LOW);
                        end
                    end
                    tlbps_pkg::PAT_SINGLE: begin
                        if (step_inc >= tlbps_pkg::SINGLE_END) begin
                            o_next.step    = 4'd0;
                            o_next.pattern = tlbps_pkg::PAT_NONE;
                            o_next.pins    = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                                 tlbps_pkg::PIN_RELEASED);
                        end else begin
                            o_next.step = step_inc;
                        end
                    end
                    tlbps_pkg::PAT_BURST: begin
                        if (step_inc >= tlbps_pkg::BURST_END) begin
                            o_next.step    = 4'd0;
                            o_next.pattern = tlbps_pkg::PAT_NONE;
                            o_next.pins    = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                                 tlbps_pkg::PIN_RELEASED);
                        end else begin
                            o_next.step = step_inc;
                            if (step_inc[0]) begin
                                o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_DRIVE_HIGH,
                                                                  tlbps_pkg::PIN_DRIVE_LOW);
                            end else begin
                                o_next.pins = tlbps_pkg::pin_pair(tlbps_pkg::PIN_RELEASED,
                                                                  tlbps_pkg::PIN_RELEASED);
                            end
                        end
                    end
                    default: ; // no pattern: nothing moves
                endcase
            end
        end
    end

endmodule

FILE: src/two_led_blink_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// two_led_blink_pattern_sequencer_core
// Two-LED pin sequencer: static modes and tick-driven blink patterns.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per command: cmd = 0 sets the display mode from
//   the mode field, cmd = 1 is one 100 ms base tick (mode ignored).
//   o_out returns exactly one item per input item: the drive/level of both
//   pins after that item, plus pattern_busy while a timed pattern runs.
//   The result is registered: the item accepted at an edge is shown at o_out
//   from that edge on (valid high in the following cycle). One item is taken
//   per cycle unless the receiver stalls; the state update is one pass
//   through tlbps_next between the state register and the result register.
//   The result register parts the two sides: i_in.ready is high while the
//   result register is empty or being taken in the same cycle, so a stalled
//   receiver holds the pending item and blocks only further input.
//   Reset (i_rst_n low, synchronous) stops any pattern, clears step and
//   prescaler counters, releases both pins and empties the result register.
// ----------------------------------------------------------------------------
module two_led_blink_pattern_sequencer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlbps_in_if.sink          i_in,
    tlbps_out_if.source       o_out
);

    tlbps_pkg::t_seq_state r_state;
    tlbps_pkg::t_seq_state n_state;
    logic                  r_out_valid;
    logic [4:0]            r_out_data;   // {busy, pins}
    logic                  accept;

    // Free to take an item when the result slot is empty or draining now
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    tlbps_next u_next (
        .i_state (r_state),
        .i_cmd   (i_in.cmd),
        .i_mode  (i_in.mode),
        .o_next  (n_state)
    );

    // Sequencer state: only moves on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pattern  <= tlbps_pkg::PAT_NONE;
            r_state.step     <= 4'd0;
            r_state.prescale <= 4'd0;
            r_state.pins     <= 4'd0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {(n_state.pattern != tlbps_pkg::PAT_NONE), n_state.pins};
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.led0_driven  = r_out_data[0];
    assign o_out.led0_level   = r_out_data[1];
    assign o_out.led1_driven  = r_out_data[2];
    assign o_out.led1_level   = r_out_data[3];
    assign o_out.pattern_busy = r_out_data[4];

endmodule

FILE: test/tlbps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbps_checker
// Watches both channels of the LED pattern sequencer. It tracks the pin and
// pattern state for every accepted command item, keeps the pin states that
// are due, and compares each returned item field by field.
// ----------------------------------------------------------------------------
module tlbps_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlbps_in_if   i_in,
    tlbps_out_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);

    // Tracked sequencer state
    tlbps_pkg::t_pattern run_pat;
    logic [3:0]          step_cnt;
    logic [3:0]          tick_cnt;
    logic [3:0]          pin_code;     // {pin1 code, pin0 code}

    // Due pin states: {busy, led1_level, led1_driven, led0_level, led0_driven}
    logic [4:0] pin_state_due [$];
    int         fails = 0;

    string field_name [5] = '{"led0_driven", "led0_level", "led1_driven",
                              "led1_level", "pattern_busy"};

    task automatic predict_pins(input logic cmd, input logic [3:0] mode,
                                output logic [4:0] res);
        logic [3:0] per;
        begin
            if (cmd == tlbps_pkg::CMD_MODE) begin
                // any mode command stops the running pattern first
                step_cnt = '0;
                tick_cnt = '0;
                run_pat  = tlbps_pkg::PAT_NONE;
                case (mode)
                    tlbps_pkg::MODE_ALL_OFF:
                        pin_code = {tlbps_pkg::PIN_RELEASED, tlbps_pkg::PIN_RELEASED};
                    tlbps_pkg::MODE_ALTERNATE: run_pat = tlbps_pkg::PAT_ALTERNATE;
                    tlbps_pkg::MODE_FLASH_5S:  run_pat = tlbps_pkg::PAT_FLASH_5S;
                    tlbps_pkg::MODE_BLINK_1:   run_pat = tlbps_pkg::PAT_BLINK_1;
                    tlbps_pkg::MODE_BLINK_2:   run_pat = tlbps_pkg::PAT_BLINK_2;
                    tlbps_pkg::MODE_LED1_ON:
                        pin_code = {tlbps_pkg::PIN_DRIVE_HIGH, tlbps_pkg::PIN_DRIVE_LOW};
                    tlbps_pkg::MODE_LED2_ON:
                        pin_code = {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_HIGH};
                    tlbps_pkg::MODE_SINGLE: begin
                        pin_code = {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_HIGH};
                        run_pat  = tlbps_pkg::PAT_SINGLE;
                    end
                    tlbps_pkg::MODE_BURST: begin
                        pin_code = {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_LOW};
                        run_pat  = tlbps_pkg::PAT_BURST;
                    end
                    tlbps_pkg::MODE_ALL_ON:
                        pin_code = {tlbps_pkg::PIN_DRIVE_HIGH, tlbps_pkg::PIN_DRIVE_HIGH};
                    default: ;      // unknown mode: pins unchanged
                endcase
            end else begin
                case (run_pat)
                    tlbps_pkg::PAT_ALTERNATE, tlbps_pkg::PAT_FLASH_5S:
                        per = tlbps_pkg::PER_500MS;
                    tlbps_pkg::PAT_BLINK_1, tlbps_pkg::PAT_BLINK_2:
                        per = tlbps_pkg::PER_1S;
                    tlbps_pkg::PAT_SINGLE: per = tlbps_pkg::PER_100MS;
                    tlbps_pkg::PAT_BURST:  per = tlbps_pkg::PER_200MS;
                    default:               per = tlbps_pkg::PER_NONE;
                endcase
                if (per != tlbps_pkg::PER_NONE) begin
                    tick_cnt = tick_cnt + 4'd1;
                    if (tick_cnt >= per) begin
                        tick_cnt = '0;
                        case (run_pat)
                            tlbps_pkg::PAT_ALTERNATE: begin
                                step_cnt = step_cnt + 4'd1;
                                if (step_cnt >= tlbps_pkg::ALT_WRAP) step_cnt = '0;
                                pin_code = step_cnt[0]
                                    ? {tlbps_pkg::PIN_DRIVE_HIGH, tlbps_pkg::PIN_DRIVE_LOW}
                                    : {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_HIGH};
                            end
                            tlbps_pkg::PAT_FLASH_5S: begin
                                step_cnt = step_cnt + 4'd1;
                                if (step_cnt < tlbps_pkg::FLASH_WRAP) begin
                                    pin_code = {tlbps_pkg::PIN_RELEASED,
                                                tlbps_pkg::PIN_RELEASED};
                                end else begin
                                    pin_code = {tlbps_pkg::PIN_DRIVE_HIGH,
                                                tlbps_pkg::PIN_DRIVE_LOW};
                                    step_cnt = '0;
                                end
                            end
                            tlbps_pkg::PAT_BLINK_1, tlbps_pkg::PAT_BLINK_2: begin
                                step_cnt = step_cnt ^ 4'd1;
                                if (step_cnt != 4'd0)
                                    pin_code = (run_pat == tlbps_pkg::PAT_BLINK_1)
                                        ? {tlbps_pkg::PIN_DRIVE_HIGH, tlbps_pkg::PIN_DRIVE_LOW}
                                        : {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_HIGH};
                                else
                                    pin_code = {tlbps_pkg::PIN_RELEASED,
                                                tlbps_pkg::PIN_RELEASED};
                            end
                            tlbps_pkg::PAT_SINGLE: begin
                                step_cnt = step_cnt + 4'd1;
                                if (step_cnt >= tlbps_pkg::SINGLE_END) begin
                                    pin_code = {tlbps_pkg::PIN_RELEASED,
                                                tlbps_pkg::PIN_RELEASED};
                                    step_cnt = '0;
                                    run_pat  = tlbps_pkg::PAT_NONE;
                                end
                            end
                            tlbps_pkg::PAT_BURST: begin
                                step_cnt = step_cnt + 4'd1;
                                pin_code = step_cnt[0]
                                    ? {tlbps_pkg::PIN_DRIVE_LOW, tlbps_pkg::PIN_DRIVE_HIGH}
                                    : {tlbps_pkg::PIN_RELEASED, tlbps_pkg::PIN_RELEASED};
                                if (step_cnt >= tlbps_pkg::BURST_END) begin
                                    pin_code = {tlbps_pkg::PIN_RELEASED,
                                                tlbps_pkg::PIN_RELEASED};
                                    step_cnt = '0;
                                    run_pat  = tlbps_pkg::PAT_NONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            res = {run_pat != tlbps_pkg::PAT_NONE, pin_code};
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [4:0] due_res;
        logic [4:0] got_res;
        if (!i_rst_n) begin
            run_pat  = tlbps_pkg::PAT_NONE;
            step_cnt = '0;
            tick_cnt = '0;
            pin_code = {tlbps_pkg::PIN_RELEASED, tlbps_pkg::PIN_RELEASED};
            pin_state_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got_res = {i_out.pattern_busy, i_out.led1_level, i_out.led1_driven,
                           i_out.led0_level, i_out.led0_driven};
                if (pin_state_due.size() == 0) begin
                    $display("%0t: unexpected item, got %b", $time, got_res);
                    fails++;
                end else begin
                    due_res = pin_state_due.pop_front();
                    for (int k = 0; k < 5; k++) begin
                        if (due_res[k] !== got_res[k]) begin
                            $display("%0t: %s expected %b, got %b", $time,
                                     field_name[k], due_res[k], got_res[k]);
                            fails++;
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_pins(i_in.cmd, i_in.mode, due_res);
                pin_state_due.push_back(due_res);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pin_state_due.size();
    end

endmodule

FILE: test/tb_two_led_blink_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_led_blink_pattern_sequencer_core
// Drives mode and tick items into the LED pattern sequencer with random gaps
// and result stalls: a directed opening, then pattern runs with random tick
// counts mixed with noise items. The checker beside the block does the
// comparing; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_two_led_blink_pattern_sequencer_core;

    localparam int NUM_ITEMS = 1850;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   calm_left [2] = '{0, 0};    // items left in a no-idle stretch, per side

    tlbps_in_if  in_ch ();
    tlbps_out_if out_ch ();

    two_led_blink_pattern_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tlbps_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle cycles before the next item on one side (0 = sender, 1 = receiver).
    // Now and then a stretch of items runs with no idling at all.
    function automatic int idle_cycles(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Present one item and hold it until the block takes it. Returns in the
    // time step of the accepting edge; valid stays high for a back-to-back item.
    task automatic send_item(input logic cmd, input logic [3:0] mode);
        int gap;
        begin
            gap = idle_cycles(0);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.cmd   <= cmd;
            in_ch.mode  <= mode;
            do @(posedge i_clk); while (!in_ch.ready);
            items_sent++;
        end
    endtask

    // Result side: random stall per item, then take the next valid item
    initial begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = idle_cycles(1);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin : stimulus
        int pick;
        int runs;
        logic [3:0] pat_mode;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= tlbps_pkg::CMD_MODE;
        in_ch.mode  <= tlbps_pkg::MODE_ALL_OFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: static modes, unknown modes, tick with no pattern
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_ALL_OFF);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_ALL_ON);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_LED1_ON);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_LED2_ON);
        send_item(tlbps_pkg::CMD_MODE, 4'd10);
        send_item(tlbps_pkg::CMD_MODE, 4'd15);
        send_item(tlbps_pkg::CMD_TICK, 4'hF);
        // single flash runs to its end and releases the pins
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_SINGLE);
        repeat (3) send_item(tlbps_pkg::CMD_TICK, 4'h0);
        // one alternate step, then an unknown mode stops it with pins held
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_ALTERNATE);
        repeat (5) send_item(tlbps_pkg::CMD_TICK, 4'hA);
        send_item(tlbps_pkg::CMD_MODE, 4'd13);
        // pattern starts cut short by the next mode
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_FLASH_5S);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_BLINK_1);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_BLINK_2);
        send_item(tlbps_pkg::CMD_MODE, tlbps_pkg::MODE_BURST);
        send_item(tlbps_pkg::CMD_TICK, 4'h0);

        // Random: mostly a pattern start followed by a random run of ticks that
        // can be long enough to wrap the slow patterns, the rest noise items
        while (items_sent < NUM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       pat_mode = tlbps_pkg::MODE_ALTERNATE;
                    1:       pat_mode = tlbps_pkg::MODE_FLASH_5S;
                    2:       pat_mode = tlbps_pkg::MODE_BLINK_1;
                    3:       pat_mode = tlbps_pkg::MODE_BLINK_2;
                    4:       pat_mode = tlbps_pkg::MODE_SINGLE;
                    default: pat_mode = tlbps_pkg::MODE_BURST;
                endcase
                send_item(tlbps_pkg::CMD_MODE, pat_mode);
                runs = $urandom_range(0, 70);
                repeat (runs) send_item(tlbps_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
            end else begin
                runs = $urandom_range(1, 4);
                repeat (runs)
                    send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain: the checker's pending count is registered; wait for it to reach zero
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_two_led_blink_pattern_sequencer_core: PASS");
        else
            $display("tb_two_led_blink_pattern_sequencer_core: FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_two_led_blink_pattern_sequencer_core: FAIL");
        $finish;
    end

endmodule

FILE: two_led_blink_pattern_sequencer_core.f
src/tlbps_pkg.sv
src/tlbps_if.sv
src/tlbps_next.sv
src/two_led_blink_pattern_sequencer_core.sv
test/tlbps_checker.sv
test/tb_two_led_blink_pattern_sequencer_core.sv
